// ===== src/tww_pkg.sv =====
package tww_pkg;

   localparam int POOL_DEPTH = 32;
   localparam int IDX_W      = $clog2(POOL_DEPTH);
   localparam int USED_W     = $clog2(POOL_DEPTH + 1);
   localparam int MAX_SLOTS  = 16;
   localparam int SLOT_W     = $clog2(MAX_SLOTS);
   localparam int SLOTS_W    = $clog2(MAX_SLOTS + 1);
   localparam int TIME_W     = 48;
   localparam int ID_W       = 32;
   localparam int TMO_W      = 16;
   localparam int CMD_W      = 2;
   localparam int KIND_W     = 3;
   localparam int CNT_W      = 6;
   localparam int DIV_W      = 16;
   localparam int DIV_CW     = $clog2(DIV_W);
   localparam int CSR_AW     = 3;
   localparam int CSR_DW     = 32;
   localparam int ENTRY_W    = ID_W + SLOT_W + TIME_W;

   localparam logic [CMD_W-1:0] CMD_ADD  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DEL  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

   localparam logic REG_TICK_INTERVAL = 1'b0;
   localparam logic REG_SLOT_COUNT    = 1'b1;

   typedef enum logic [KIND_W-1:0] {
      KIND_ADDED,
      KIND_BAD_TIMEOUT,
      KIND_POOL_FULL,
      KIND_DELETED,
      KIND_NOT_FOUND,
      KIND_EXPIRED,
      KIND_TICK_DONE
   } kind_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LATCH,
      OP_DIV_TICKS,
      OP_DIV_CUR,
      OP_DIV_SLOT,
      OP_SAVE_TICKS,
      OP_SAVE_CUR,
      OP_ADD_WRITE,
      OP_SEARCH_INIT,
      OP_SCAN_INIT,
      OP_READ,
      OP_SEARCH_EVAL,
      OP_SCAN_EVAL,
      OP_SCAN_END,
      OP_TICK_END
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      emit;
      kind_type  kind;
   } dp_cmd_type;

   typedef struct packed {
      logic used_zero;
      logic pool_full;
      logic bad_timeout;
      logic div_busy;
      logic scan_last;
      logic remove;
      logic found;
      logic rsp_free;
   } dp_status_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [SLOT_W-1:0] slot;
      logic [TIME_W-1:0] expiry;
   } entry_type;

endpackage

// ===== src/tww_req_if.sv =====
interface tww_req_if import tww_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic [CMD_W-1:0]        command;
   logic signed [ID_W-1:0]  timer_id;
   logic signed [TMO_W-1:0] timeout;

   modport source (output valid, command, timer_id, timeout, input ready);
   modport sink (input valid, command, timer_id, timeout, output ready);
endinterface

// ===== src/tww_rsp_if.sv =====
interface tww_rsp_if import tww_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [KIND_W-1:0]      kind;
   logic signed [ID_W-1:0] expired_id;
   logic [CNT_W-1:0]       expired_count;
   logic                   last;

   modport source (output valid, kind, expired_id, expired_count, last, input ready);
   modport sink (input valid, kind, expired_id, expired_count, last, output ready);
endinterface

// ===== src/timing_wheel_timer.sv =====
// Add: two 16-step divisions in the shared restoring divider.
// Delete: reads and checks each pool entry to search, then again to compact if found.
// Tick: position mod slot_count in the divider, then reads and checks each pool entry.
// One item at a time; the next is taken while the last result still waits.
// Synchronous reset empties the pool and zeroes position and time; no clear pass.
module timing_wheel_timer import tww_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   tww_req_if.sink           req_ch,
   tww_rsp_if.source         rsp_ch,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);
   logic [TMO_W-1:0]   tick_interval_ff;
   logic [SLOTS_W-1:0] slot_count_ff;
   logic [TMO_W-1:0]   interval;
   logic [SLOTS_W-1:0] slots;
   logic               csr_write;
   dp_cmd_type         cmd;
   dp_status_type      st;

   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_interval_ff <= TMO_W'(1);
         slot_count_ff    <= SLOTS_W'(10);
      end else if (csr_write) begin
         if (csr_paddr[2] == REG_SLOT_COUNT) begin
            slot_count_ff <= csr_pwdata[SLOTS_W-1:0];
         end else begin
            tick_interval_ff <= csr_pwdata[TMO_W-1:0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_SLOT_COUNT) ?
                       {{(CSR_DW-SLOTS_W){1'b0}}, slot_count_ff} :
                       {{(CSR_DW-TMO_W){1'b0}}, tick_interval_ff};

   assign interval = (tick_interval_ff == '0) ? TMO_W'(1) : tick_interval_ff;
   always_comb begin
      if (slot_count_ff == '0) begin
         slots = SLOTS_W'(1);
      end else if (slot_count_ff > SLOTS_W'(MAX_SLOTS)) begin
         slots = SLOTS_W'(MAX_SLOTS);
      end else begin
         slots = slot_count_ff;
      end
   end

   tww_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_command (req_ch.command),
      .req_ready   (req_ch.ready),
      .st          (st),
      .cmd         (cmd)
   );

   tww_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .st                (st),
      .req_command       (req_ch.command),
      .req_timer_id      (req_ch.timer_id),
      .req_timeout       (req_ch.timeout),
      .interval          (interval),
      .slots             (slots),
      .rsp_ready         (rsp_ch.ready),
      .rsp_valid         (rsp_ch.valid),
      .rsp_kind          (rsp_ch.kind),
      .rsp_expired_id    (rsp_ch.expired_id),
      .rsp_expired_count (rsp_ch.expired_count),
      .rsp_last          (rsp_ch.last)
   );

   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> st.rsp_free) else $error("result loaded over a pending one");

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_ch.valid) else $error("loaded result not presented");

   a_idle_div: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> !st.div_busy) else $error("divider busy while idle");
endmodule

// ===== src/tww_ram.sv =====
module tww_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ===== src/tww_div.sv =====
module tww_div import tww_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic             busy,
   output logic [DIV_W-1:0] quotient,
   output logic [DIV_W-1:0] remainder
);
   logic              busy_ff;
   logic [DIV_CW-1:0] count_ff;
   logic [DIV_W-1:0]  quo_ff, rem_ff, div_ff;
   logic [DIV_W:0]    trial, diff;

   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign diff  = trial - {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && count_ff == DIV_CW'(DIV_W - 1)) begin
         busy_ff <= 1'b0;
      end
      if (start) begin
         count_ff <= '0;
         quo_ff   <= dividend;
         rem_ff   <= '0;
         div_ff   <= divisor;
      end else if (busy_ff) begin
         count_ff <= count_ff + 1'b1;
         if (trial >= {1'b0, div_ff}) begin
            rem_ff <= diff[DIV_W-1:0];
            quo_ff <= {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_ff <= trial[DIV_W-1:0];
            quo_ff <= {quo_ff[DIV_W-2:0], 1'b0};
         end
      end
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule

// ===== src/tww_datapath.sv =====
module tww_datapath import tww_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  dp_cmd_type              cmd,
   output dp_status_type           st,
   input  logic [CMD_W-1:0]        req_command,
   input  logic signed [ID_W-1:0]  req_timer_id,
   input  logic signed [TMO_W-1:0] req_timeout,
   input  logic [TMO_W-1:0]        interval,
   input  logic [SLOTS_W-1:0]      slots,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic [KIND_W-1:0]       rsp_kind,
   output logic signed [ID_W-1:0]  rsp_expired_id,
   output logic [CNT_W-1:0]        rsp_expired_count,
   output logic                    rsp_last
);
   logic [USED_W-1:0] used_ff;
   logic [SLOT_W-1:0] pos_ff, cur_ff, best_slot_ff;
   logic [TIME_W-1:0] now_ff;
   logic [DIV_W-1:0]  ticks_ff;
   logic [ID_W-1:0]   sid_ff;
   logic [TMO_W-1:0]  tmo_ff;
   logic              tick_ff, found_ff;
   logic [IDX_W-1:0]  rd_ff, best_idx_ff;
   logic [USED_W-1:0] wr_ff;
   logic [CNT_W-1:0]  cnt_ff;

   logic              rsp_valid_ff, rsp_last_ff;
   logic [KIND_W-1:0] rsp_kind_ff;
   logic [ID_W-1:0]   rsp_id_ff;
   logic [CNT_W-1:0]  rsp_cnt_ff;

   logic             div_start, div_busy;
   logic [DIV_W-1:0] div_dividend, div_divisor, div_quo, div_rem;

   entry_type        rd_entry, new_entry, ram_wdata;
   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr;
   logic             expire, search_hit, remove;

   assign div_start = cmd.op == OP_DIV_TICKS || cmd.op == OP_DIV_CUR || cmd.op == OP_DIV_SLOT;

   always_comb begin
      case (cmd.op)
         OP_DIV_TICKS: begin
            div_dividend = tmo_ff;
            div_divisor  = interval;
         end
         OP_DIV_CUR: begin
            div_dividend = {{(DIV_W-SLOT_W){1'b0}}, pos_ff};
            div_divisor  = {{(DIV_W-SLOTS_W){1'b0}}, slots};
         end
         default: begin
            div_dividend = {{(DIV_W-SLOT_W){1'b0}}, pos_ff} + ticks_ff;
            div_divisor  = {{(DIV_W-SLOTS_W){1'b0}}, slots};
         end
      endcase
   end

   tww_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign new_entry.id     = sid_ff;
   assign new_entry.slot   = div_rem[SLOT_W-1:0];
   assign new_entry.expiry = now_ff + {{(TIME_W-TMO_W){1'b0}}, tmo_ff};

   assign expire     = rd_entry.slot == cur_ff && rd_entry.expiry <= now_ff;
   assign remove     = tick_ff ? expire : (rd_ff == best_idx_ff);
   assign search_hit = rd_entry.id == sid_ff && {1'b0, rd_entry.slot} < slots &&
                       (!found_ff || rd_entry.slot < best_slot_ff);

   assign ram_we    = cmd.op == OP_ADD_WRITE || (cmd.op == OP_SCAN_EVAL && !remove);
   assign ram_waddr = (cmd.op == OP_ADD_WRITE) ? used_ff[IDX_W-1:0] : wr_ff[IDX_W-1:0];
   assign ram_wdata = (cmd.op == OP_ADD_WRITE) ? new_entry : rd_entry;

   tww_ram #(.WIDTH(ENTRY_W), .DEPTH(POOL_DEPTH)) u_pool (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (cmd.op == OP_READ),
      .raddr (rd_ff),
      .rdata (rd_entry)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         pos_ff  <= '0;
         now_ff  <= '0;
      end else begin
         case (cmd.op)
            OP_ADD_WRITE: used_ff <= used_ff + 1'b1;
            OP_SCAN_END:  used_ff <= wr_ff;
            OP_TICK_END: begin
               used_ff <= wr_ff;
               now_ff  <= now_ff + {{(TIME_W-TMO_W){1'b0}}, interval};
               if ({1'b0, cur_ff} + 1'b1 == slots) begin
                  pos_ff <= '0;
               end else begin
                  pos_ff <= cur_ff + 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LATCH: begin
            sid_ff  <= req_timer_id;
            tmo_ff  <= req_timeout;
            tick_ff <= req_command == CMD_TICK;
         end
         OP_SAVE_TICKS: ticks_ff <= (div_quo == '0) ? DIV_W'(1) : div_quo;
         OP_SAVE_CUR:   cur_ff <= div_rem[SLOT_W-1:0];
         OP_SEARCH_INIT: begin
            rd_ff    <= '0;
            found_ff <= 1'b0;
         end
         OP_SCAN_INIT: begin
            rd_ff  <= '0;
            wr_ff  <= '0;
            cnt_ff <= '0;
         end
         OP_SEARCH_EVAL: begin
            rd_ff <= rd_ff + 1'b1;
            if (search_hit) begin
               found_ff     <= 1'b1;
               best_idx_ff  <= rd_ff;
               best_slot_ff <= rd_entry.slot;
            end
         end
         OP_SCAN_EVAL: begin
            rd_ff <= rd_ff + 1'b1;
            if (remove) begin
               cnt_ff <= cnt_ff + 1'b1;
            end else begin
               wr_ff <= wr_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         rsp_kind_ff <= cmd.kind;
         rsp_last_ff <= cmd.kind != KIND_EXPIRED;
         rsp_cnt_ff  <= (cmd.kind == KIND_TICK_DONE) ? cnt_ff : '0;
         case (cmd.kind)
            KIND_EXPIRED: rsp_id_ff <= rd_entry.id;
            KIND_DELETED: rsp_id_ff <= sid_ff;
            default:      rsp_id_ff <= '0;
         endcase
      end
   end

   assign st.used_zero   = used_ff == '0;
   assign st.pool_full   = used_ff == USED_W'(POOL_DEPTH);
   assign st.bad_timeout = tmo_ff == '0 || tmo_ff[TMO_W-1];
   assign st.div_busy    = div_busy;
   assign st.scan_last   = {1'b0, rd_ff} + 1'b1 == used_ff;
   assign st.remove      = remove;
   assign st.found       = found_ff;
   assign st.rsp_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_expired_id    = rsp_id_ff;
   assign rsp_expired_count = rsp_cnt_ff;
   assign rsp_last          = rsp_last_ff;
endmodule

// ===== src/tww_ctrl.sv =====
module tww_ctrl import tww_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [CMD_W-1:0] req_command,
   output logic             req_ready,
   input  dp_status_type    st,
   output dp_cmd_type       cmd
);
   typedef enum logic [4:0] {
      S_IDLE,
      S_ADD_CHECK,
      S_ADD_TICKS_WAIT,
      S_ADD_SLOT,
      S_ADD_SLOT_WAIT,
      S_ADD_WRITE,
      S_DEL_INIT,
      S_DEL_READ,
      S_DEL_EVAL,
      S_DEL_CHECK,
      S_SHIFT_READ,
      S_SHIFT_EVAL,
      S_SHIFT_END,
      S_TICK_CUR,
      S_TICK_CUR_WAIT,
      S_TICK_INIT,
      S_TICK_READ,
      S_TICK_EVAL,
      S_TICK_END,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;
   kind_type  kind_ff, kind_in;

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      req_ready = 1'b0;
      cmd.op    = OP_NONE;
      cmd.emit  = 1'b0;
      cmd.kind  = kind_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = OP_LATCH;
               case (req_command)
                  CMD_ADD:  state_in = S_ADD_CHECK;
                  CMD_DEL:  state_in = S_DEL_INIT;
                  CMD_TICK: state_in = S_TICK_CUR;
                  default:  state_in = S_IDLE;
               endcase
            end
         end
         S_ADD_CHECK: begin
            if (st.bad_timeout) begin
               kind_in  = KIND_BAD_TIMEOUT;
               state_in = S_EMIT;
            end else if (st.pool_full) begin
               kind_in  = KIND_POOL_FULL;
               state_in = S_EMIT;
            end else begin
               cmd.op   = OP_DIV_TICKS;
               state_in = S_ADD_TICKS_WAIT;
            end
         end
         S_ADD_TICKS_WAIT: begin
            if (!st.div_busy) begin
               cmd.op   = OP_SAVE_TICKS;
               state_in = S_ADD_SLOT;
            end
         end
         S_ADD_SLOT: begin
            cmd.op   = OP_DIV_SLOT;
            state_in = S_ADD_SLOT_WAIT;
         end
         S_ADD_SLOT_WAIT: begin
            if (!st.div_busy) begin
               state_in = S_ADD_WRITE;
            end
         end
         S_ADD_WRITE: begin
            cmd.op   = OP_ADD_WRITE;
            kind_in  = KIND_ADDED;
            state_in = S_EMIT;
         end
         S_DEL_INIT: begin
            cmd.op = OP_SEARCH_INIT;
            if (st.used_zero) begin
               kind_in  = KIND_NOT_FOUND;
               state_in = S_EMIT;
            end else begin
               state_in = S_DEL_READ;
            end
         end
         S_DEL_READ: begin
            cmd.op   = OP_READ;
            state_in = S_DEL_EVAL;
         end
         S_DEL_EVAL: begin
            cmd.op   = OP_SEARCH_EVAL;
            state_in = st.scan_last ? S_DEL_CHECK : S_DEL_READ;
         end
         S_DEL_CHECK: begin
            if (st.found) begin
               cmd.op   = OP_SCAN_INIT;
               state_in = S_SHIFT_READ;
            end else begin
               kind_in  = KIND_NOT_FOUND;
               state_in = S_EMIT;
            end
         end
         S_SHIFT_READ: begin
            cmd.op   = OP_READ;
            state_in = S_SHIFT_EVAL;
         end
         S_SHIFT_EVAL: begin
            cmd.op   = OP_SCAN_EVAL;
            state_in = st.scan_last ? S_SHIFT_END : S_SHIFT_READ;
         end
         S_SHIFT_END: begin
            cmd.op   = OP_SCAN_END;
            kind_in  = KIND_DELETED;
            state_in = S_EMIT;
         end
         S_TICK_CUR: begin
            cmd.op   = OP_DIV_CUR;
            state_in = S_TICK_CUR_WAIT;
         end
         S_TICK_CUR_WAIT: begin
            if (!st.div_busy) begin
               cmd.op   = OP_SAVE_CUR;
               state_in = S_TICK_INIT;
            end
         end
         S_TICK_INIT: begin
            cmd.op   = OP_SCAN_INIT;
            state_in = st.used_zero ? S_TICK_END : S_TICK_READ;
         end
         S_TICK_READ: begin
            cmd.op   = OP_READ;
            state_in = S_TICK_EVAL;
         end
         S_TICK_EVAL: begin
            if (!(st.remove && !st.rsp_free)) begin
               cmd.op   = OP_SCAN_EVAL;
               cmd.emit = st.remove;
               cmd.kind = KIND_EXPIRED;
               state_in = st.scan_last ? S_TICK_END : S_TICK_READ;
            end
         end
         S_TICK_END: begin
            if (st.rsp_free) begin
               cmd.op   = OP_TICK_END;
               cmd.emit = 1'b1;
               cmd.kind = KIND_TICK_DONE;
               state_in = S_IDLE;
            end
         end
         S_EMIT: begin
            if (st.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kind_ff  <= KIND_ADDED;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end
endmodule
